[rtl/core/scr_col_pkg.sv]
// Shared types, constants and decode functions for the screen column address generator.
// No dependencies; every module of the block imports this package.
package scr_col_pkg;

    localparam int COLUMNS       = 32;
    localparam int COL_W         = $clog2(COLUMNS);
    localparam int MAX_RAM_BANKS = 4;
    localparam int BANK_W        = 3;
    localparam int BASE_W        = 18;
    localparam int OFF_W         = 19;
    localparam int XOFF_W        = 16;
    localparam int HEIGHT_W      = 9;
    localparam int SIZE_W        = 16;
    localparam int UNIT_W        = 3;

    localparam logic [7:0] MODE_SEL0_MASK = 8'h04;
    localparam logic [7:0] MODE_SEL1_MASK = 8'h20;
    localparam logic [7:0] MODE_CM_MASK   = 8'h03;

    localparam logic [1:0]          SEL_256    = 2'd3;
    localparam logic [HEIGHT_W-1:0] HEIGHT_256 = 9'd256;
    localparam logic [SIZE_W-1:0]   SIZE_256   = 16'((256 / 8) * (256 / 8) * 32);

    // One decoded run: everything the back end needs to emit all columns.
    typedef struct packed {
        logic [BASE_W-1:0]   base;
        logic [HEIGHT_W-1:0] height;
        logic [1:0]          cmode;
        logic [UNIT_W-1:0]   unit;
        logic                tall;
    } t_job;

    function automatic logic [HEIGHT_W-1:0] height_of(input logic [1:0] sel);
        logic [HEIGHT_W-1:0] h;
        case (sel)
            2'd0:    h = 9'd128;
            2'd1:    h = 9'd160;
            2'd2:    h = 9'd192;
            default: h = 9'd256;
        endcase
        return h;
    endfunction

    // log2 of the size multiplier 16, 32, 32, 64
    function automatic logic [2:0] mult_shift(input logic [1:0] cmode);
        logic [2:0] s;
        case (cmode)
            2'd0:    s = 3'd4;
            2'd1:    s = 3'd5;
            2'd2:    s = 3'd5;
            default: s = 3'd6;
        endcase
        return s;
    endfunction

    function automatic logic [UNIT_W-1:0] unit_of(input logic [1:0] cmode);
        logic [UNIT_W-1:0] u;
        case (cmode)
            2'd0:    u = 3'd1;
            2'd1:    u = 3'd2;
            default: u = 3'd4;
        endcase
        return u;
    endfunction

endpackage

[rtl/core/scr_col_front.sv]
// Front end: holds the bank-count register, decodes one input beat and clamps the base.
// Depends on scr_col_pkg; feeds scr_col_queue.
module scr_col_front
    import scr_col_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [BANK_W-1:0] i_cfg_wdata,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [7:0]        i_mode_byte,
    input  logic [7:0]        i_base_byte,
    input  logic              i_obj_mode,
    output logic              o_job_valid,
    input  logic              i_job_ready,
    output t_job              o_job
);

    logic [BANK_W-1:0] r_bank_cnt;
    logic              r_vld;
    t_job              r_job;
    t_job              n_job;

    logic [1:0]          sel;
    logic [1:0]          cmode;
    logic [HEIGHT_W-1:0] real_h;
    logic [SIZE_W-1:0]   size;
    logic [BANK_W-1:0]   banks;
    logic [OFF_W-1:0]    ram_end;
    logic [OFF_W-1:0]    base_raw;
    logic [OFF_W-1:0]    base_sum;
    logic [OFF_W-1:0]    base_clamp;
    logic                accept;

    assign o_stall     = r_vld && !i_job_ready;
    assign accept      = i_valid && !o_stall;
    assign o_job_valid = r_vld;
    assign o_job       = r_job;

    always_comb begin
        sel    = {|(i_mode_byte & MODE_SEL1_MASK), |(i_mode_byte & MODE_SEL0_MASK)};
        cmode  = 2'(i_mode_byte & MODE_CM_MASK);
        real_h = height_of(sel);
        if (sel == SEL_256) begin
            size = SIZE_256;
        end else begin
            // rows of 8 lines, 32 tiles a row, multiplier per colour mode
            size = SIZE_W'(real_h >> 3) << (5 + mult_shift(cmode));
        end
        banks = r_bank_cnt;
        if (banks == '0) begin
            banks = BANK_W'(1);
        end else if (banks > BANK_W'(MAX_RAM_BANKS)) begin
            banks = BANK_W'(MAX_RAM_BANKS);
        end
        ram_end  = OFF_W'(banks) << 16;
        base_raw = OFF_W'({i_base_byte, 10'b0});
        base_sum = base_raw + OFF_W'(size);
        if (base_sum > ram_end) begin
            base_clamp = ram_end - OFF_W'(size);
        end else begin
            base_clamp = base_raw;
        end
        n_job.base   = base_clamp[BASE_W-1:0];
        n_job.tall   = i_obj_mode || (sel == SEL_256);
        n_job.height = i_obj_mode ? HEIGHT_256 : real_h;
        n_job.cmode  = cmode;
        n_job.unit   = unit_of(cmode);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank_cnt <= BANK_W'(1);
            r_vld      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_bank_cnt <= i_cfg_wdata;
            end
            r_vld <= accept || (r_vld && !i_job_ready);
        end
        if (accept) begin
            r_job <= n_job;
        end
    end

endmodule

[rtl/core/scr_col_queue.sv]
// Two-entry job queue between the front and back ends.
// Depends on scr_col_pkg for the job type.
module scr_col_queue
    import scr_col_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    output logic o_ready,
    input  t_job i_job,
    output logic o_valid,
    input  logic i_pop,
    output t_job o_job
);

    t_job       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       push_ok;
    logic       pop_ok;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_job   = r_mem[r_rd_ptr];
    assign push_ok = i_push && o_ready;
    assign pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop_ok) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + 2'(push_ok) - 2'(pop_ok);
        end
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

[rtl/core/scr_col_back.sv]
// Back end: walks the columns of the job at the queue head, one result beat per cycle unless stalled.
// Depends on scr_col_pkg; reads from scr_col_queue.
module scr_col_back
    import scr_col_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_valid,
    input  t_job                i_job,
    output logic                o_job_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [COL_W-1:0]    o_column_index,
    output logic [OFF_W-1:0]    o_column_offset,
    output logic [XOFF_W-1:0]   o_x_offset,
    output logic [BASE_W-1:0]   o_screen_base,
    output logic [HEIGHT_W-1:0] o_screen_height,
    output logic [1:0]          o_color_mode,
    output logic                o_last
);

    localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);

    logic [COL_W-1:0] r_col;
    logic             advance;
    logic             emit;
    logic             upper;
    logic [COL_W-1:0] k;
    logic [6:0]       ku;
    logic [OFF_W-1:0] n_off;
    logic [XOFF_W:0]  n_xo;

    assign advance   = !o_valid || !i_stall;
    assign emit      = advance && i_job_valid;
    assign o_job_pop = emit && (r_col == LAST_COL);

    always_comb begin
        // tall layout: two halves of 16 columns each
        upper = i_job.tall && r_col[COL_W-1];
        k     = i_job.tall ? {1'b0, r_col[COL_W-2:0]} : r_col;
        ku    = 7'(k * i_job.unit);
        if (i_job.tall) begin
            n_off = OFF_W'(i_job.base) + (OFF_W'(ku) << 8)
                  + (upper ? (OFF_W'(i_job.unit) << 13) : '0);
            n_xo  = (17'(ku) << 4) + (upper ? (17'(i_job.unit) << 12) : '0);
        end else begin
            n_off = OFF_W'(i_job.base) + (OFF_W'(ku) << 4);
            n_xo  = 17'(i_job.height * ku) << 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            o_valid <= 1'b0;
        end else if (advance) begin
            o_valid <= i_job_valid;
            if (emit) begin
                r_col <= r_col + COL_W'(1);
            end
        end
        if (emit) begin
            o_column_index  <= r_col;
            o_column_offset <= n_off;
            o_x_offset      <= n_xo[XOFF_W-1:0];
            o_screen_base   <= i_job.base;
            o_screen_height <= i_job.height;
            o_color_mode    <= i_job.cmode;
            o_last          <= (r_col == LAST_COL);
        end
    end

endmodule

[rtl/core/screen_column_address_gen_core.sv]
// Top level of the screen column address generator: front end, job queue, back end.
// Depends on scr_col_pkg, scr_col_front, scr_col_queue and scr_col_back.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall): one beat carries a mode byte, a base
//   byte and the object-mode bit. Each accepted beat yields 32 result beats on
//   the output channel (o_out_valid / i_out_stall), columns 0 through 31 in order,
//   with o_last high on column 31.
//   Path: an accepted beat is registered in the front end, pushed into the queue,
//   then loaded into the output register as its first column.
//   Rate: one column per cycle while i_out_stall is low; the column
//   counter in the back end emitting from the queue head sets that rate.
//   Up to three runs can wait at once (front register and two queue entries,
//   the head entry being walked), so new input is taken while earlier runs emit.
//   Stall: when i_out_stall is high the output register holds its beat and the
//   column counter holds; once the queue is full and the front register holds a job, o_in_stall rises.
//   Configuration: i_cfg_we with i_cfg_wdata writes the RAM bank count (reset 1);
//   write it only while no run is in flight.
//   Reset: synchronous, active low; clears the queue, the column counter and
//   both valids, and sets the bank count to 1.
module screen_column_address_gen_core
    import scr_col_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [BANK_W-1:0]   i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [7:0]          i_mode_byte,
    input  logic [7:0]          i_base_byte,
    input  logic                i_obj_mode,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [COL_W-1:0]    o_column_index,
    output logic [OFF_W-1:0]    o_column_offset,
    output logic [XOFF_W-1:0]   o_x_offset,
    output logic [BASE_W-1:0]   o_screen_base,
    output logic [HEIGHT_W-1:0] o_screen_height,
    output logic [1:0]          o_color_mode,
    output logic                o_last
);

    // front -> queue
    logic front_valid;
    logic queue_ready;
    t_job front_job;

    // queue -> back
    logic head_valid;
    logic head_pop;
    t_job head_job;

    // Decode and clamp; hold the decoded job until the queue takes it.
    scr_col_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_in_valid),
        .o_stall     (o_in_stall),
        .i_mode_byte (i_mode_byte),
        .i_base_byte (i_base_byte),
        .i_obj_mode  (i_obj_mode),
        .o_job_valid (front_valid),
        .i_job_ready (queue_ready),
        .o_job       (front_job)
    );

    // Buffer jobs so the front keeps accepting while the back walks columns.
    scr_col_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .o_ready (queue_ready),
        .i_job   (front_job),
        .o_valid (head_valid),
        .i_pop   (head_pop),
        .o_job   (head_job)
    );

    // Emit one column per cycle unless i_out_stall holds it; drop the head job after its last column.
    scr_col_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_job_valid     (head_valid),
        .i_job           (head_job),
        .o_job_pop       (head_pop),
        .o_valid         (o_out_valid),
        .i_stall         (i_out_stall),
        .o_column_index  (o_column_index),
        .o_column_offset (o_column_offset),
        .o_x_offset      (o_x_offset),
        .o_screen_base   (o_screen_base),
        .o_screen_height (o_screen_height),
        .o_color_mode    (o_color_mode),
        .o_last          (o_last)
    );

endmodule
